// File: hw/rtl/iir_first_order_look_ahead_macros.svh
// Assertion macros shared by the filter RTL. Each macro samples on the
// rising edge of clock and is switched off while reset is high.
`ifndef IIR_FIRST_ORDER_LOOK_AHEAD_MACROS_SVH
`define IIR_FIRST_ORDER_LOOK_AHEAD_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/iirla_pkg.sv
package iirla_pkg;

   // Default sample width and the number of bits kept after truncation.
   localparam int DEFAULT_SAMPLE_BITS = 14;
   localparam int DEFAULT_KEPT_BITS   = 5;

   // Coefficient values after reset, in Q0.13.
   localparam int RESET_COEF_B0 = 3447;
   localparam int RESET_COEF_B1 = 3447;
   localparam int RESET_COEF_A1 = -1298;

   // Number of register stages from the input to the output register.
   localparam int PIPE_STAGES = 7;

   // Register port geometry.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   typedef enum logic [1:0] {
      REG_COEF_B0 = 2'd0,
      REG_COEF_B1 = 2'd1,
      REG_COEF_A1 = 2'd2
   } reg_index_type;

endpackage

// File: hw/rtl/iir_first_order_look_ahead.sv
// First-order IIR filter with look-ahead and coefficient truncation. Each
// transaction on the req_ channel carries one signed Q0.13 sample and yields
// exactly one filtered sample on the rsp_ channel, in order. The datapath is a
// seven-stage pipeline: one multiplier or one add-and-truncate sits between
// registers, so a new transaction can be taken on every clock cycle while
// the output is not stalled. Because the look-ahead form makes the look-ahead
// term depend only on the previous input and on the intermediate value from
// two samples back, there is no feedback loop across the multiplier and the
// throughput is one sample per cycle unless the output stalls. Each
// stage has its own valid bit and moves forward whenever the stage after it
// is empty or moving, so a stalled output only stalls the stages that are
// actually full and bubbles are squeezed out. The three coefficients are
// written over the APB-style port at byte addresses 0 (b0), 4 (b1) and 8
// (a1); they should only be changed while no transaction is in flight. Reset
// clears the filter history and restores the default coefficients.
module iir_first_order_look_ahead
   import iirla_pkg::*;
#(
   parameter int SAMPLE_BITS = DEFAULT_SAMPLE_BITS,
   parameter int KEPT_BITS   = DEFAULT_KEPT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // Input sample channel.
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic signed [SAMPLE_BITS-1:0]   req_sample_in,
   // Filtered sample channel.
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic signed [SAMPLE_BITS:0]     rsp_sample_out,
   // Coefficient register port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [CSR_ADDR_BITS-1:0]        paddr,
   input  logic [CSR_DATA_BITS-1:0]        pwdata,
   output logic [CSR_DATA_BITS-1:0]        prdata,
   output logic                            pready
);

   // Short names for the widths used throughout.
   localparam int SB    = SAMPLE_BITS;
   // Low bits cleared on inputs, coefficients and feedback terms.
   localparam int CUT_C = SAMPLE_BITS - KEPT_BITS - 1;
   // Low bits cleared on the intermediate value w and the look-ahead term.
   localparam int CUT_W = SAMPLE_BITS - KEPT_BITS;
   // Every product is rescaled by this floor shift.
   localparam int SHIFT = SAMPLE_BITS - 1;

   // ------------------------------------------------------------------
   // Coefficient registers
   // ------------------------------------------------------------------
   logic signed [SB-1:0] coef_b0_ff;
   logic signed [SB-1:0] coef_b1_ff;
   logic signed [SB-1:0] coef_a1_ff;
   logic                 csr_write;
   reg_index_type        csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = reg_index_type'(paddr[3:2]);

   // A write to an address beyond the three registers is simply dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_b0_ff <= SB'(RESET_COEF_B0);
         coef_b1_ff <= SB'(RESET_COEF_B1);
         coef_a1_ff <= SB'(RESET_COEF_A1);
      end else if (csr_write) begin
         case (csr_index)
            REG_COEF_B0: coef_b0_ff <= $signed(pwdata[SB-1:0]);
            REG_COEF_B1: coef_b1_ff <= $signed(pwdata[SB-1:0]);
            REG_COEF_A1: coef_a1_ff <= $signed(pwdata[SB-1:0]);
            default: ;
         endcase
      end
   end

   // Reads return the register sign-extended to the data width.
   always_comb begin
      case (csr_index)
         REG_COEF_B0: prdata = {{(CSR_DATA_BITS-SB){coef_b0_ff[SB-1]}}, coef_b0_ff};
         REG_COEF_B1: prdata = {{(CSR_DATA_BITS-SB){coef_b1_ff[SB-1]}}, coef_b1_ff};
         REG_COEF_A1: prdata = {{(CSR_DATA_BITS-SB){coef_a1_ff[SB-1]}}, coef_a1_ff};
         default:     prdata = '0;
      endcase
   end

   // Truncated coefficients: shifting right and back left clears the low
   // bits with floor rounding, as required for negative values.
   logic signed [SB-1:0] b0_trunc;
   logic signed [SB-1:0] b1_trunc;
   logic signed [SB-1:0] a1_trunc;

   assign b0_trunc = (coef_b0_ff >>> CUT_C) <<< CUT_C;
   assign b1_trunc = (coef_b1_ff >>> CUT_C) <<< CUT_C;
   assign a1_trunc = (coef_a1_ff >>> CUT_C) <<< CUT_C;

   // ------------------------------------------------------------------
   // Pipeline flow control
   // ------------------------------------------------------------------
   // A stage can take new data when it is empty or when its contents move on
   // in the same cycle. The chain is resolved from the output backwards.
   logic [PIPE_STAGES-1:0] valid_ff;
   logic [PIPE_STAGES-1:0] valid_in;
   logic [PIPE_STAGES:0]   stage_ready;
   logic [PIPE_STAGES-1:0] up_valid;
   logic [PIPE_STAGES-1:0] load;

   always_comb begin
      stage_ready[PIPE_STAGES] = rsp_ready;
      for (int k = PIPE_STAGES - 1; k >= 0; k--) begin
         stage_ready[k] = ~valid_ff[k] | stage_ready[k+1];
      end
      up_valid = {valid_ff[PIPE_STAGES-2:0], req_valid};
      load     = stage_ready[PIPE_STAGES-1:0] & up_valid;
      for (int k = 0; k < PIPE_STAGES; k++) begin
         valid_in[k] = stage_ready[k] ? up_valid[k] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_ready = stage_ready[0];
   assign rsp_valid = valid_ff[PIPE_STAGES-1];

   // ------------------------------------------------------------------
   // Stage 1: truncate the new sample and pair it with the previous one.
   // ------------------------------------------------------------------
   logic signed [SB-1:0] x_trunc;
   logic signed [SB-1:0] prev_input_ff;
   logic signed [SB-1:0] x1_ff;
   logic signed [SB-1:0] p1_ff;

   assign x_trunc = (req_sample_in >>> CUT_C) <<< CUT_C;

   // The previous input is filter state, so it advances only on a
   // transaction and is cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_input_ff <= '0;
      end else if (load[0]) begin
         prev_input_ff <= x_trunc;
      end
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         x1_ff <= x_trunc;
         p1_ff <= prev_input_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 2: feedback product of the previous input with a1.
   // ------------------------------------------------------------------
   logic signed [2*SB-1:0] m2_in;
   logic signed [2*SB-1:0] m2_ff;
   logic signed [SB-1:0]   x2_ff;
   logic signed [SB-1:0]   p2_ff;

   assign m2_in = p1_ff * a1_trunc;

   always_ff @(posedge clock) begin
      if (load[1]) begin
         m2_ff <= m2_in;
         x2_ff <= x1_ff;
         p2_ff <= p1_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 3: intermediate value w and its two-sample history.
   // ------------------------------------------------------------------
   logic signed [2*SB-1:0] fb;
   logic signed [2*SB-1:0] w_diff;
   logic signed [2*SB-1:0] w_full;
   logic signed [SB:0]     w3_in;
   logic signed [SB:0]     w3_ff;
   logic signed [SB:0]     wold3_ff;
   logic signed [SB-1:0]   p3_ff;
   logic signed [SB:0]     hist0_ff;
   logic signed [SB:0]     hist1_ff;

   assign fb     = ((m2_ff >>> SHIFT) >>> CUT_C) <<< CUT_C;
   assign w_diff = x2_ff - fb;
   assign w_full = (w_diff >>> CUT_W) <<< CUT_W;
   // The difference always fits in one bit more than a sample.
   assign w3_in  = $signed(w_full[SB:0]);

   // The history follows the samples in order, so it is updated exactly
   // when a sample enters this stage; hist1 then holds w from two samples
   // back for the look-ahead term.
   always_ff @(posedge clock) begin
      if (reset) begin
         hist0_ff <= '0;
         hist1_ff <= '0;
      end else if (load[2]) begin
         hist0_ff <= w3_in;
         hist1_ff <= hist0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (load[2]) begin
         w3_ff    <= w3_in;
         wold3_ff <= hist1_ff;
         p3_ff    <= p2_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 4: the two products that use w.
   // ------------------------------------------------------------------
   logic signed [2*SB:0] pb0_in;
   logic signed [2*SB:0] pa_in;
   logic signed [2*SB:0] pb0_4_ff;
   logic signed [2*SB:0] pa4_ff;
   logic signed [SB-1:0] p4_ff;

   assign pb0_in = w3_ff * b0_trunc;
   assign pa_in  = wold3_ff * a1_trunc;

   always_ff @(posedge clock) begin
      if (load[3]) begin
         pb0_4_ff <= pb0_in;
         pa4_ff   <= pa_in;
         p4_ff    <= p3_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 5: look-ahead term and rescaling of the b0 product.
   // ------------------------------------------------------------------
   logic signed [2*SB:0] wa;
   logic signed [2*SB:0] ahead_full;
   logic signed [2*SB:0] s0_full;
   logic signed [SB+1:0] ahead5_ff;
   logic signed [SB+1:0] s0_5_ff;

   assign wa         = ((pa4_ff >>> SHIFT) >>> CUT_C) <<< CUT_C;
   assign ahead_full = ((p4_ff - wa) >>> CUT_W) <<< CUT_W;
   assign s0_full    = pb0_4_ff >>> SHIFT;

   always_ff @(posedge clock) begin
      if (load[4]) begin
         ahead5_ff <= $signed(ahead_full[SB+1:0]);
         s0_5_ff   <= $signed(s0_full[SB+1:0]);
      end
   end

   // ------------------------------------------------------------------
   // Stage 6: look-ahead term times b1.
   // ------------------------------------------------------------------
   logic signed [2*SB+1:0] pb1_in;
   logic signed [2*SB+1:0] pb1_6_ff;
   logic signed [SB+1:0]   s0_6_ff;

   assign pb1_in = ahead5_ff * b1_trunc;

   always_ff @(posedge clock) begin
      if (load[5]) begin
         pb1_6_ff <= pb1_in;
         s0_6_ff  <= s0_5_ff;
      end
   end

   // ------------------------------------------------------------------
   // Stage 7: final sum, wrapped to the output width; output register.
   // ------------------------------------------------------------------
   logic signed [2*SB+1:0] y_sum;
   logic signed [SB:0]     y7_ff;

   assign y_sum = (pb1_6_ff >>> SHIFT) + s0_6_ff;

   always_ff @(posedge clock) begin
      if (load[6]) begin
         y7_ff <= $signed(y_sum[SB:0]);
      end
   end

   assign rsp_sample_out = y7_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "iir_first_order_look_ahead_macros.svh"

   `IIR_ASSERT_NEXT(a_accept_fills_first, req_valid && req_ready, valid_ff[0],
      "accepted transaction did not reach the first stage")
   `IIR_ASSERT_NOW(a_empty_first_ready, !valid_ff[0], req_ready,
      "input refused although the first stage is empty")
   `IIR_ASSERT_NEXT(a_history_shift, load[2],
      hist0_ff == w3_ff && hist1_ff == $past(hist0_ff),
      "w history out of step with the pipeline")
   `IIR_ASSERT_NEXT(a_stalled_stage_holds, valid_ff[3] && !stage_ready[4],
      valid_ff[3] && $stable(pb0_4_ff), "stalled middle stage lost its contents")

endmodule
